/* rtl/dwpi_pkg.sv */
// Package for the dual-wheel PI speed controller.
// Holds field widths, register indexes, command codes and the config struct.
// No dependencies.
package dwpi_pkg;

    localparam int SPEED_WIDTH    = 16;
    localparam int INTEGRAL_WIDTH = 24;
    localparam int DUTY_WIDTH     = 16;
    localparam int GAIN_WIDTH     = 24;
    localparam int LIMIT_WIDTH    = 23;
    localparam int DUTY_SHIFT     = 20;

    localparam int ERR_WIDTH    = SPEED_WIDTH + 1;
    localparam int PROD_P_WIDTH = GAIN_WIDTH + 1 + ERR_WIDTH;
    localparam int PROD_I_WIDTH = GAIN_WIDTH + 1 + INTEGRAL_WIDTH;
    localparam int ACC_WIDTH    =
        ((PROD_P_WIDTH > PROD_I_WIDTH) ? PROD_P_WIDTH : PROD_I_WIDTH) + 1;
    localparam int SCALED_WIDTH = ACC_WIDTH - DUTY_SHIFT;

    localparam int CALC_BASE    = (INTEGRAL_WIDTH > ERR_WIDTH) ? INTEGRAL_WIDTH : ERR_WIDTH;
    localparam int CALC_WIDTH   =
        ((CALC_BASE > LIMIT_WIDTH + 1) ? CALC_BASE : LIMIT_WIDTH + 1) + 2;

    localparam int IN_DATA_WIDTH  = ((4 * SPEED_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_WIDTH = ((2 * DUTY_WIDTH + 7) / 8) * 8;

    localparam int CFG_ADDR_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 24;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_ENABLE         = 3'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_GAIN_P         = 3'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_GAIN_I         = 3'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_DUTY_UPPER     = 3'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_DUTY_LOWER     = 3'd4;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_INTEGRAL_LIMIT = 3'd5;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic                           enable;
        logic [GAIN_WIDTH-1:0]          gain_p;
        logic [GAIN_WIDTH-1:0]          gain_i;
        logic signed [DUTY_WIDTH-1:0]   duty_upper;
        logic signed [DUTY_WIDTH-1:0]   duty_lower;
        logic [LIMIT_WIDTH-1:0]         integral_limit;
    } t_cfg;

endpackage

/* rtl/dwpi_cfg.sv */
// Configuration register file for the dual-wheel PI controller.
// Depends on dwpi_pkg.
module dwpi_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dwpi_pkg::CFG_ADDR_WIDTH-1:0] i_cfg_addr,
    input  logic [dwpi_pkg::CFG_DATA_WIDTH-1:0] i_cfg_wdata,
    output dwpi_pkg::t_cfg                     o_cfg
);

    dwpi_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable         <= 1'b1;
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i         <= '0;
            r_cfg.duty_upper     <= 16'sh7FFF;
            r_cfg.duty_lower     <= 16'sh8000;
            r_cfg.integral_limit <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                dwpi_pkg::REG_ENABLE:     r_cfg.enable <= i_cfg_wdata[0];
                dwpi_pkg::REG_GAIN_P:
                    r_cfg.gain_p <= i_cfg_wdata[dwpi_pkg::GAIN_WIDTH-1:0];
                dwpi_pkg::REG_GAIN_I:
                    r_cfg.gain_i <= i_cfg_wdata[dwpi_pkg::GAIN_WIDTH-1:0];
                dwpi_pkg::REG_DUTY_UPPER:
                    r_cfg.duty_upper <= i_cfg_wdata[dwpi_pkg::DUTY_WIDTH-1:0];
                dwpi_pkg::REG_DUTY_LOWER:
                    r_cfg.duty_lower <= i_cfg_wdata[dwpi_pkg::DUTY_WIDTH-1:0];
                dwpi_pkg::REG_INTEGRAL_LIMIT:
                    r_cfg.integral_limit <= i_cfg_wdata[dwpi_pkg::LIMIT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/dwpi_lane.sv */
// One wheel's PI datapath: products, floor shift, clamps, conditional integration.
// Combinational; depends on dwpi_pkg.
module dwpi_lane (
    input  dwpi_pkg::t_cfg                                i_cfg,
    input  logic signed [dwpi_pkg::ERR_WIDTH-1:0]         i_err,
    input  logic signed [dwpi_pkg::INTEGRAL_WIDTH-1:0]    i_integral,
    output logic signed [dwpi_pkg::DUTY_WIDTH-1:0]        o_duty,
    output logic signed [dwpi_pkg::INTEGRAL_WIDTH-1:0]    o_integral
);

    localparam int CW = dwpi_pkg::CALC_WIDTH;
    localparam int SW = dwpi_pkg::SCALED_WIDTH;
    localparam logic signed [CW-1:0] WMAX =
        (CW'(1) << (dwpi_pkg::INTEGRAL_WIDTH - 1)) - CW'(1);

    logic signed [dwpi_pkg::PROD_P_WIDTH-1:0] prod_p;
    logic signed [dwpi_pkg::PROD_I_WIDTH-1:0] prod_i;
    logic signed [dwpi_pkg::ACC_WIDTH-1:0]    acc;
    logic signed [SW-1:0]                     scaled;
    logic signed [SW-1:0]                     upper_x;
    logic signed [SW-1:0]                     lower_x;
    logic signed [SW-1:0]                     duty_hi;
    logic                                     above;
    logic                                     below;
    logic                                     add_en;
    logic signed [CW-1:0]                     sum;
    logic signed [CW-1:0]                     lim_raw;
    logic signed [CW-1:0]                     lim;
    logic signed [CW-1:0]                     sum_c;

    always_comb begin
        prod_p  = $signed({1'b0, i_cfg.gain_p}) * i_err;
        prod_i  = $signed({1'b0, i_cfg.gain_i}) * i_integral;
        acc     = dwpi_pkg::ACC_WIDTH'(prod_p) + dwpi_pkg::ACC_WIDTH'(prod_i);
        // arithmetic shift: floor
        scaled  = acc[dwpi_pkg::ACC_WIDTH-1:dwpi_pkg::DUTY_SHIFT];
        upper_x = SW'(i_cfg.duty_upper);
        lower_x = SW'(i_cfg.duty_lower);
        above   = scaled > upper_x;
        below   = scaled < lower_x;

        duty_hi = above ? upper_x : scaled;
        o_duty  = (duty_hi < lower_x) ? i_cfg.duty_lower
                                      : duty_hi[dwpi_pkg::DUTY_WIDTH-1:0];

        if (above) begin
            add_en = i_err < 0;
        end else if (below) begin
            add_en = i_err > 0;
        end else begin
            add_en = 1'b1;
        end

        sum     = CW'(i_integral) + (add_en ? CW'(i_err) : CW'(0));
        lim_raw = CW'($signed({1'b0, i_cfg.integral_limit}));
        lim     = (lim_raw > WMAX) ? WMAX : lim_raw;

        if (sum > lim) begin
            sum_c = lim;
        end else if (sum < -lim) begin
            sum_c = -lim;
        end else begin
            sum_c = sum;
        end
        o_integral = sum_c[dwpi_pkg::INTEGRAL_WIDTH-1:0];
    end

endmodule

/* rtl/dual_wheel_pi_speed_control_core.sv */
// Top level of the dual-wheel PI speed controller.
// Depends on dwpi_pkg, dwpi_cfg and dwpi_lane.
//
// Two positional PI loops, one beat per cycle while the output flows. An input
// beat is registered with the speed errors formed, then one pass through both
// lanes (two multiplies each, floor shift, clamps, conditional integration)
// loads the integrals and the output register. A result passes from the input
// register to the output register; a new beat is taken every cycle while the
// output flows, the integral feedback running combinationally through the lanes.
// Clear beats and updates while disabled produce no output beat. Registers
// should be written only while no beat is in flight; the block does not enforce it.
module dual_wheel_pi_speed_control_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [dwpi_pkg::CFG_ADDR_WIDTH-1:0] i_cfg_addr,
    input  logic [dwpi_pkg::CFG_DATA_WIDTH-1:0] i_cfg_wdata,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: target_left, target_right, speed_left, speed_right
    input  logic [dwpi_pkg::IN_DATA_WIDTH-1:0]  s_axis_tdata,
    // tuser: cmd
    input  logic                                s_axis_tuser,
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: duty_left, duty_right
    output logic [dwpi_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata
);

    localparam int SPW = dwpi_pkg::SPEED_WIDTH;
    localparam int EW  = dwpi_pkg::ERR_WIDTH;
    localparam int IW  = dwpi_pkg::INTEGRAL_WIDTH;
    localparam int DW  = dwpi_pkg::DUTY_WIDTH;

    dwpi_pkg::t_cfg cfg;

    logic signed [SPW-1:0] tgt_l;
    logic signed [SPW-1:0] tgt_r;
    logic signed [SPW-1:0] spd_l;
    logic signed [SPW-1:0] spd_r;
    logic signed [EW-1:0]  n_err_l;
    logic signed [EW-1:0]  n_err_r;

    logic                  r_s1_valid;
    logic                  r_s1_cmd;
    logic signed [EW-1:0]  r_s1_err_l;
    logic signed [EW-1:0]  r_s1_err_r;

    logic signed [IW-1:0]  r_int_l;
    logic signed [IW-1:0]  r_int_r;
    logic signed [IW-1:0]  n_int_l;
    logic signed [IW-1:0]  n_int_r;
    logic signed [DW-1:0]  n_duty_l;
    logic signed [DW-1:0]  n_duty_r;

    logic                  r_out_valid;
    logic signed [DW-1:0]  r_out_duty_l;
    logic signed [DW-1:0]  r_out_duty_r;

    logic                  out_free;
    logic                  s1_result;
    logic                  s1_adv;
    logic                  in_acc;

    dwpi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign tgt_l   = s_axis_tdata[SPW-1:0];
    assign tgt_r   = s_axis_tdata[2*SPW-1:SPW];
    assign spd_l   = s_axis_tdata[3*SPW-1:2*SPW];
    assign spd_r   = s_axis_tdata[4*SPW-1:3*SPW];
    assign n_err_l = EW'(tgt_l) - EW'(spd_l);
    assign n_err_r = EW'(tgt_r) - EW'(spd_r);

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_result     = (r_s1_cmd == dwpi_pkg::CMD_UPDATE) && cfg.enable;
    assign s1_adv        = r_s1_valid && (out_free || !s1_result);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    dwpi_lane u_lane_l (
        .i_cfg      (cfg),
        .i_err      (r_s1_err_l),
        .i_integral (r_int_l),
        .o_duty     (n_duty_l),
        .o_integral (n_int_l)
    );

    dwpi_lane u_lane_r (
        .i_cfg      (cfg),
        .i_err      (r_s1_err_r),
        .i_integral (r_int_r),
        .o_duty     (n_duty_r),
        .o_integral (n_int_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_int_l     <= '0;
            r_int_r     <= '0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                if (r_s1_cmd == dwpi_pkg::CMD_CLEAR) begin
                    r_int_l <= '0;
                    r_int_r <= '0;
                end else if (s1_result) begin
                    r_int_l <= n_int_l;
                    r_int_r <= n_int_r;
                end
            end

            if (s1_adv && s1_result) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd   <= s_axis_tuser;
            r_s1_err_l <= n_err_l;
            r_s1_err_r <= n_err_r;
        end
        if (s1_adv && s1_result) begin
            r_out_duty_l <= n_duty_l;
            r_out_duty_r <= n_duty_r;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = dwpi_pkg::OUT_DATA_WIDTH'({r_out_duty_r, r_out_duty_l});

`ifndef NO_ASSERTIONS
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_cmd == dwpi_pkg::CMD_CLEAR) |=> (r_int_l == '0 && r_int_r == '0))
        else $error("integrals not cleared");

    a_out_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_adv && s1_result))
        else $error("output beat without enabled update");

    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_valid && s1_result && r_out_valid))
        else $error("input stalled without a blocked update");
`endif

endmodule

/* tb/sv/dwpi_duty_checker.sv */
`timescale 1ns / 1ps
// Duty checker for the dual-wheel PI speed controller: follows register writes and input
// beats, predicts both clamped duties and compares every output beat. Depends on dwpi_pkg.
module dwpi_duty_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dwpi_pkg::CFG_ADDR_WIDTH-1:0] i_cfg_addr,
    input  logic [dwpi_pkg::CFG_DATA_WIDTH-1:0] i_cfg_wdata,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    // tdata: target_left, target_right, speed_left, speed_right
    input  logic [dwpi_pkg::IN_DATA_WIDTH-1:0]  i_s_tdata,
    // tuser: cmd
    input  logic                                i_s_tuser,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: duty_left, duty_right
    input  logic [dwpi_pkg::OUT_DATA_WIDTH-1:0] i_m_tdata,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_result_count
);
    import dwpi_pkg::*;

    localparam longint INTEG_MAX = (longint'(1) << (INTEGRAL_WIDTH - 1)) - 1;
    localparam int     SW        = SPEED_WIDTH;

    typedef struct packed {
        logic signed [DUTY_WIDTH-1:0]     duty;
        logic signed [INTEGRAL_WIDTH-1:0] integ;
    } t_wheel_step;

    typedef struct packed {
        logic signed [DUTY_WIDTH-1:0] left;
        logic signed [DUTY_WIDTH-1:0] right;
    } t_duty_pair;

    t_cfg                             loop_cfg;
    logic signed [INTEGRAL_WIDTH-1:0] integ_left;
    logic signed [INTEGRAL_WIDTH-1:0] integ_right;
    t_duty_pair                       duty_queue[$];
    t_wheel_step                      step_l;
    t_wheel_step                      step_r;
    t_duty_pair                       want;
    t_duty_pair                       got;
    int                               fail_count   = 0;
    int                               result_count = 0;

    // one positional PI step, old integral feeds the duty
    function automatic t_wheel_step pi_wheel(
        input logic signed [INTEGRAL_WIDTH-1:0] integ_old,
        input logic signed [SPEED_WIDTH-1:0]    target,
        input logic signed [SPEED_WIDTH-1:0]    speed
    );
        longint      err;
        longint      sum;
        longint      duty;
        longint      integ;
        longint      limit;
        longint      hi;
        longint      lo;
        t_wheel_step res;
        err   = longint'(target) - longint'(speed);
        sum   = longint'(loop_cfg.gain_p) * err + longint'(loop_cfg.gain_i) * longint'(integ_old);
        duty  = sum >>> DUTY_SHIFT;
        hi    = longint'($signed(loop_cfg.duty_upper));
        lo    = longint'($signed(loop_cfg.duty_lower));
        limit = longint'(loop_cfg.integral_limit);
        if (limit > INTEG_MAX) begin
            limit = INTEG_MAX;
        end
        integ = longint'(integ_old);
        if (duty > hi) begin
            if (err < 0) integ = integ + err;
        end else if (duty < lo) begin
            if (err > 0) integ = integ + err;
        end else begin
            integ = integ + err;
        end
        if (duty > hi) duty = hi;
        if (duty < lo) duty = lo;
        if (integ > limit) integ = limit;
        if (integ < -limit) integ = -limit;
        res.duty  = duty[DUTY_WIDTH-1:0];
        res.integ = integ[INTEGRAL_WIDTH-1:0];
        return res;
    endfunction

    task automatic report(input string msg);
        if (fail_count < 40) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            loop_cfg.enable         = 1'b1;
            loop_cfg.gain_p         = '0;
            loop_cfg.gain_i         = '0;
            loop_cfg.duty_upper     = 16'sh7FFF;
            loop_cfg.duty_lower     = 16'sh8000;
            loop_cfg.integral_limit = '1;
            integ_left              = '0;
            integ_right             = '0;
            duty_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_ENABLE:         loop_cfg.enable = i_cfg_wdata[0];
                    REG_GAIN_P:         loop_cfg.gain_p = i_cfg_wdata[GAIN_WIDTH-1:0];
                    REG_GAIN_I:         loop_cfg.gain_i = i_cfg_wdata[GAIN_WIDTH-1:0];
                    REG_DUTY_UPPER:     loop_cfg.duty_upper = i_cfg_wdata[DUTY_WIDTH-1:0];
                    REG_DUTY_LOWER:     loop_cfg.duty_lower = i_cfg_wdata[DUTY_WIDTH-1:0];
                    REG_INTEGRAL_LIMIT: loop_cfg.integral_limit = i_cfg_wdata[LIMIT_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == CMD_CLEAR) begin
                    integ_left  = '0;
                    integ_right = '0;
                end else if (loop_cfg.enable) begin
                    step_l      = pi_wheel(integ_left, i_s_tdata[SW-1:0], i_s_tdata[3*SW-1:2*SW]);
                    step_r      = pi_wheel(integ_right, i_s_tdata[2*SW-1:SW], i_s_tdata[4*SW-1:3*SW]);
                    integ_left  = step_l.integ;
                    integ_right = step_r.integ;
                    want.left   = step_l.duty;
                    want.right  = step_r.duty;
                    duty_queue.push_back(want);
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.left  = i_m_tdata[DUTY_WIDTH-1:0];
                got.right = i_m_tdata[2*DUTY_WIDTH-1:DUTY_WIDTH];
                if (duty_queue.size() == 0) begin
                    report($sformatf("output beat %0d/%0d with no update waiting",
                                     got.left, got.right));
                end else begin
                    want = duty_queue.pop_front();
                    if (got.left !== want.left) begin
                        report($sformatf("result %0d duty_left got %0d want %0d",
                                         result_count, got.left, want.left));
                    end
                    if (got.right !== want.right) begin
                        report($sformatf("result %0d duty_right got %0d want %0d",
                                         result_count, got.right, want.right));
                    end
                    result_count++;
                end
            end
        end
        o_pending      = duty_queue.size();
        o_fail_count   = fail_count;
        o_result_count = result_count;
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Top of the dual-wheel PI speed controller testbench: clock, reset, stimulus and verdict.
// Depends on dwpi_pkg, dual_wheel_pi_speed_control_core and dwpi_duty_checker.
module tb;
    import dwpi_pkg::*;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_SPARE = 3'd7;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 135;
    localparam int EDGE_ITEMS  = 60;
    localparam int QUIET_LIMIT = 2000;

    typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_CHOKE} t_rx_mode;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_we      = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_WIDTH-1:0] i_cfg_wdata   = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_DATA_WIDTH-1:0]  s_axis_tdata  = '0;
    logic                      s_axis_tuser  = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b1;
    logic [OUT_DATA_WIDTH-1:0] m_axis_tdata;

    int       fail_count;
    int       pending_duties;
    int       duties_checked;
    int       quiet_cycles   = 0;
    int       burst_left     = 0;
    int       items_sent     = 0;
    int       clears_sent    = 0;
    int       settings_count = 0;
    t_rx_mode rx_mode        = RX_OPEN;
    logic [5:0] rx_tick      = '0;
    int       rx_hold        = 0;

    dual_wheel_pi_speed_control_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    dwpi_duty_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_s_tuser      (s_axis_tuser),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending_duties),
        .o_result_count (duties_checked)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: switches stall style whenever the 6-bit rx_tick counter wraps
    always @(negedge i_clk) begin
        rx_tick <= rx_tick + 1'b1;
        if (rx_tick == '0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
        end
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (rx_hold != 0) begin
                    m_axis_tready <= 1'b0;
                    rx_hold       <= rx_hold - 1;
                end else begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) rx_hold <= $urandom_range(1, 12);
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int rnd16();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int clip16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input logic cmd, input int tl, input int tr, input int sl, input int sr);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= {$urandom, $urandom};
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {16'(sr), 16'(sl), 16'(tr), 16'(tl)};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
        if (cmd == CMD_CLEAR) clears_sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_duties != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] addr, input logic [23:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
    endtask

    // unused bits above the enable, duty and limit fields get random values; they must be ignored
    task automatic program_regs(input t_cfg c);
        settle();
        write_reg(REG_ENABLE, {23'($urandom), c.enable});
        write_reg(REG_GAIN_P, c.gain_p);
        write_reg(REG_GAIN_I, c.gain_i);
        write_reg(REG_DUTY_UPPER, {8'($urandom), c.duty_upper});
        write_reg(REG_DUTY_LOWER, {8'($urandom), c.duty_lower});
        write_reg(REG_INTEGRAL_LIMIT, {1'($urandom), c.integral_limit});
        write_reg(REG_SPARE, 24'($urandom));
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    initial begin : stimulus
        t_cfg regs;
        int   tl;
        int   tr;
        int   sl;
        int   sr;
        int   len;
        int   pick;
        int   counted;
        int   quota;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: zero gains, duties stay at zero
        send_beat(CMD_UPDATE, 32767, -32768, -32768, 32767);
        send_beat(CMD_UPDATE, -32768, 32767, 32767, -32768);
        send_beat(CMD_CLEAR, -1, -1, -1, -1);
        send_beat(CMD_UPDATE, 0, 0, 0, 0);

        // unit proportional gain: duty follows error
        regs.enable         = 1'b1;
        regs.gain_p         = 24'h100000;
        regs.gain_i         = 24'h000100;
        regs.duty_upper     = 16'sd1000;
        regs.duty_lower     = -16'sd1000;
        regs.integral_limit = 23'd100000;
        program_regs(regs);
        send_beat(CMD_UPDATE, 0, 0, 0, 0);
        send_beat(CMD_UPDATE, 32767, -32768, -32768, 32767);
        send_beat(CMD_UPDATE, 500, -500, 0, 0);
        send_beat(CMD_UPDATE, 500, -500, 0, 0);
        send_beat(CMD_UPDATE, -2000, 2000, 0, 0);
        send_beat(CMD_CLEAR, 0, 0, 0, 0);
        send_beat(CMD_UPDATE, 100, -100, 0, 0);

        // lower clamp above upper clamp
        regs.duty_lower = 16'sd2000;
        program_regs(regs);
        send_beat(CMD_UPDATE, 0, 0, 0, 0);
        send_beat(CMD_UPDATE, 5000, -5000, 0, 0);
        send_beat(CMD_UPDATE, -5000, 5000, 0, 0);

        // tight integral clamp under full integral gain
        regs.duty_upper     = 16'sh7FFF;
        regs.duty_lower     = 16'sh8000;
        regs.gain_i         = '1;
        regs.integral_limit = 23'd10;
        program_regs(regs);
        send_beat(CMD_UPDATE, 3000, -3000, 0, 0);
        send_beat(CMD_UPDATE, 3000, -3000, 0, 0);
        send_beat(CMD_UPDATE, -7, 7, 0, 0);

        // disabled: updates are dropped, clear still zeroes the integrals
        regs.enable = 1'b0;
        program_regs(regs);
        send_beat(CMD_UPDATE, 1234, -1234, 0, 0);
        send_beat(CMD_CLEAR, 1, 2, 3, 4);
        send_beat(CMD_UPDATE, -1234, 1234, 0, 0);
        regs.enable = 1'b1;
        program_regs(regs);
        send_beat(CMD_UPDATE, 0, 0, 0, 0);

        for (int phase = 0; phase < PHASES; phase++) begin
            regs.enable = 1'b1;
            quota       = PHASE_ITEMS;
            if (phase == 0) begin
                regs.gain_p         = '1;
                regs.gain_i         = '1;
                regs.duty_upper     = 16'sh7FFF;
                regs.duty_lower     = 16'sh8000;
                regs.integral_limit = '1;
                quota               = EDGE_ITEMS;
            end else if (phase == 1) begin
                regs.gain_p         = '0;
                regs.gain_i         = '0;
                regs.duty_upper     = 16'sh8000;
                regs.duty_lower     = 16'sh7FFF;
                regs.integral_limit = '0;
                quota               = EDGE_ITEMS;
            end else begin
                regs.gain_p     = 24'($urandom_range(0, (1 << $urandom_range(8, 24)) - 1));
                regs.gain_i     = 24'($urandom_range(0, (1 << $urandom_range(0, 18)) - 1));
                regs.duty_upper = 16'($urandom_range(0, 32767));
                regs.duty_lower = 16'(-int'($urandom_range(0, 32768)));
                if ($urandom_range(0, 4) == 0) regs.duty_lower = 16'($urandom_range(0, 32767));
                regs.integral_limit = ($urandom_range(0, 3) == 0) ? '1 :
                    23'($urandom_range(0, (1 << $urandom_range(4, 23)) - 1));
            end
            program_regs(regs);
            counted = 0;
            while (counted < quota) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    send_beat(CMD_CLEAR, rnd16(), rnd16(), rnd16(), rnd16());
                    counted++;
                end else if (pick < 22) begin
                    send_beat(CMD_UPDATE, rnd16(), rnd16(), rnd16(), rnd16());
                    counted++;
                end else begin
                    // wheels spinning up toward their targets with noisy speed readings
                    tl  = ($urandom_range(0, 2) == 0) ? rnd16() : int'($urandom_range(0, 8191)) - 4096;
                    tr  = ($urandom_range(0, 2) == 0) ? rnd16() : int'($urandom_range(0, 8191)) - 4096;
                    sl  = rnd16();
                    sr  = rnd16();
                    len = $urandom_range(4, 30);
                    for (int k = 0; k < len && counted < quota; k++) begin
                        send_beat(CMD_UPDATE, tl, tr, sl, sr);
                        counted++;
                        sl = clip16(sl + (tl - sl) / 4 + int'($urandom_range(0, 255)) - 128);
                        sr = clip16(sr + (tr - sr) / 4 + int'($urandom_range(0, 255)) - 128);
                    end
                end
            end
        end

        settle();
        $display("Sent %0d input beats (%0d clears) under %0d register settings;",
                 items_sent, clears_sent, settings_count);
        $display("checked %0d duty beats with random gaps and output stalls.", duties_checked);
        if (fail_count == 0) begin
            $display("** dual_wheel_pi_speed_control_core: PASSED **");
        end else begin
            $display("** dual_wheel_pi_speed_control_core: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        do @(posedge i_clk); while (quiet_cycles < QUIET_LIMIT);
        $display("Watchdog: %0d cycles without a beat on either side.", quiet_cycles);
        $display("** dual_wheel_pi_speed_control_core: FAILED **");
        $finish;
    end

endmodule

/* dual_wheel_pi_speed_control_core.f */
rtl/dwpi_pkg.sv
rtl/dwpi_cfg.sv
rtl/dwpi_lane.sv
rtl/dual_wheel_pi_speed_control_core.sv
tb/sv/dwpi_duty_checker.sv
tb/sv/tb.sv
